[sv/icr_pkg.sv]
// Shared types, constants and arithmetic helpers of the interflow cell router.
package icr_pkg;

    // Input transaction: one grid cell with its parameters.
    typedef struct packed {
        logic [11:0] cell_index;
        logic [11:0] downstream_index;
        logic        has_downstream;
        logic [23:0] channel_length;
        logic [31:0] vadose_excess;
        logic [31:0] conductivity;
        logic [31:0] decay_coefficient;
        logic [31:0] channel_factor;
        logic [31:0] slope_tangent;
    } cell_in_t;

    // Output transaction: the routing result of one cell.
    typedef struct packed {
        logic [11:0] out_cell;
        logic [31:0] remaining_vadose;
        logic [31:0] flow_to_channel;
        logic [31:0] flow_downstream;
    } cell_out_t;

    // Start request to a multi-cycle arithmetic unit with two operands.
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } op_req_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_STEP_OVER_DX = 2'd0;
    localparam logic [1:0] CFG_INV_CELL     = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD    = 2'd2;

    localparam logic [31:0] STEP_OVER_DX_RST = 32'd56623104;
    localparam logic [31:0] INV_CELL_RST     = 32'd42949673;
    localparam logic [31:0] THRESHOLD_RST    = 32'd1;

    // Number of exponent bits handled by the factor table.
    localparam int EXP_BITS = 29;

    localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
    localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;

    typedef logic [63:0] exp_tab_t [EXP_BITS];

    // Q2.62 product with round half up.
    function automatic logic [63:0] mul_q62(input logic [127:0] prod);
        return prod[125:62] + {63'd0, prod[61]};
    endfunction

    // Product shifted right, saturated to 64 bits.
    function automatic logic [63:0] mul_shr(input logic [127:0] prod, input int unsigned sh);
        logic [127:0] shifted;
        shifted = prod >> sh;
        return (|shifted[127:64]) ? '1 : shifted[63:0];
    endfunction

    // Factors exp(-2^(i-24)) in Q2.62; each is the rounded square of the one before.
    function automatic exp_tab_t make_exp_tab();
        exp_tab_t     tab;
        logic [63:0]  t;
        logic [127:0] sq;
        t = ONE_Q62 - 64'h0000_0040_0000_0000 + 64'h0000_0000_0000_2000;
        for (int i = 0; i < EXP_BITS; i++) begin
            tab[i] = t;
            sq = {64'd0, t} * {64'd0, t};
            t = mul_q62(sq);
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TAB = make_exp_tab();

endpackage

[sv/icr_mul.sv]
// Shared 64 by 64 multiplier built from four 32 by 32 partial products.
module icr_mul (
    input  logic             clk,
    input  logic             rst_n,
    input  icr_pkg::op_req_t req,
    output logic             done,
    output logic [127:0]     prod
);
    import icr_pkg::*;

    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [1:0]   cnt_reg;
    logic         run_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   pp_sh_reg;
    logic         pp_vld_reg;
    logic         pp_last_reg;
    logic [127:0] acc_reg;
    logic         done_reg;
    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [127:0] pp_shifted;

    // Operand halves for the current partial product.
    always_comb
    begin
        a_half = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
        b_half = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
        unique case (pp_sh_reg)
            2'd0:    pp_shifted = {64'd0, pp_reg};
            2'd1:    pp_shifted = {32'd0, pp_reg, 32'd0};
            default: pp_shifted = {pp_reg, 64'd0};
        endcase
    end

    // Sequencing of partial products and accumulation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            run_reg     <= 1'b0;
            pp_vld_reg  <= 1'b0;
            pp_last_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg   <= pp_vld_reg && pp_last_reg;
            pp_vld_reg <= run_reg;
            if (req.start)
            begin
                cnt_reg <= '0;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                pp_last_reg <= (cnt_reg == 2'd3);
                cnt_reg     <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    // Operand, partial product and accumulator registers.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (pp_vld_reg)
        begin
            acc_reg <= acc_reg + pp_shifted;
        end
        if (run_reg)
        begin
            pp_reg    <= {32'd0, a_half} * {32'd0, b_half};
            pp_sh_reg <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

[sv/icr_div.sv]
// Restoring 64 by 64 bit divider, one quotient bit per cycle.
module icr_div (
    input  logic             clk,
    input  logic             rst_n,
    input  icr_pkg::op_req_t req,
    output logic             done,
    output logic [63:0]      quot
);
    import icr_pkg::*;

    logic [63:0] rem_reg;
    logic [63:0] quo_reg;
    logic [63:0] dsr_reg;
    logic [5:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;
    logic [64:0] trial;
    logic        fits;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb
    begin
        trial = {rem_reg, quo_reg[63]};
        fits  = (trial >= {1'b0, dsr_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.a;
            dsr_reg <= req.b;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? 64'(trial - {1'b0, dsr_reg}) : trial[63:0];
            quo_reg <= {quo_reg[62:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

[sv/icr_sqrt.sv]
// Integer square root of a 64 bit value, two radicand bits per cycle.
module icr_sqrt (
    input  logic             clk,
    input  logic             rst_n,
    input  icr_pkg::op_req_t req,
    output logic             done,
    output logic [63:0]      root
);
    import icr_pkg::*;

    logic [63:0] q_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic        run_reg;
    logic        done_reg;
    logic [63:0] trial;
    logic        fits;

    always_comb
    begin
        trial = res_reg + bit_reg;
        fits  = (q_reg >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
            end
            else if (run_reg && bit_reg[0])
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Digit-by-digit root; the trial bit walks down from the top power of four.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg   <= req.a;
            res_reg <= '0;
            bit_reg <= ONE_Q62;
        end
        else if (run_reg)
        begin
            if (fits)
            begin
                q_reg   <= q_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg;

endmodule

[sv/icr_store.sv]
// Inflow store memory with a clearing pass after reset.
module icr_store #(
    parameter int NUM_CELLS = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [$clog2(NUM_CELLS)-1:0] rd_addr,
    output logic [31:0]                  rd_data,
    input  logic                         wr_en,
    input  logic [$clog2(NUM_CELLS)-1:0] wr_addr,
    input  logic [31:0]                  wr_data,
    output logic                         busy
);
    import icr_pkg::*;

    localparam int AW = $clog2(NUM_CELLS);

    logic [31:0]   mem [NUM_CELLS];
    logic [31:0]   rd_data_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic          clr_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;

    // The clearing pass owns the write port until every entry is zero.
    always_comb
    begin
        mem_we    = clr_reg || wr_en;
        mem_waddr = clr_reg ? clr_cnt_reg : wr_addr;
        mem_wdata = clr_reg ? 32'd0 : wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else if (clr_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(NUM_CELLS - 1))
            begin
                clr_reg <= 1'b0;
            end
        end
    end

    // Synchronous memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_reg;

endmodule

[sv/interflow_cell_router_top.sv]
// Top level of the interflow cell router: sequencer, datapath and unit wiring.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall   in_data  (cell_in_t)
//   out       output     out_valid / out_stall out_data (cell_out_t)
//   cfg       input      cfg_we               cfg_index, cfg_data
//
// One cell is worked on at a time. A cell at or below the threshold goes straight
// to the output; for a routed cell without channel the time is set by the two
// divisions and the square root. A channel adds work in the shared multiplier,
// with one product more for each set bit of the exponent argument. After reset the
// store is cleared, one entry a cycle; no cell is taken meanwhile. A finished
// result waits in the output register while the next cell is accepted.
module interflow_cell_router_top #(
    parameter int NUM_CELLS = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  icr_pkg::cell_in_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output icr_pkg::cell_out_t out_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import icr_pkg::*;

    localparam int AW = $clog2(NUM_CELLS);

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_LOAD = 15'b000000000000010,
        S_KXW  = 15'b000000000000100,
        S_EXP  = 15'b000000000001000,
        S_EXPW = 15'b000000000010000,
        S_PW   = 15'b000000000100000,
        S_CH   = 15'b000000001000000,
        S_SSW  = 15'b000000010000000,
        S_SQW  = 15'b000000100000000,
        S_D1W  = 15'b000001000000000,
        S_ALW  = 15'b000010000000000,
        S_GW   = 15'b000100000000000,
        S_D2W  = 15'b001000000000000,
        S_ADD  = 15'b010000000000000,
        S_OUT  = 15'b100000000000000
    } state_t;

    state_t       state_reg;
    cell_in_t     item_reg;
    logic         cell_ok_reg;
    logic         dst_ok_reg;
    logic [31:0]  sod_reg;
    logic [31:0]  ics_reg;
    logic [31:0]  thr_reg;
    logic [31:0]  avail_reg;
    logic [55:0]  lenics_reg;
    logic [28:0]  x_reg;
    logic         x_big_reg;
    logic [63:0]  e_reg;
    logic [4:0]   bit_reg;
    logic [2:0]   pstep_reg;
    logic [63:0]  p_reg;
    logic [63:0]  om_reg;
    logic [31:0]  to_chn_reg;
    logic [31:0]  keep_reg;
    logic [31:0]  down_reg;
    cell_out_t    out_reg;
    logic         out_valid_reg;
    logic         mul_start_reg;
    logic [63:0]  mul_a_reg;
    logic [63:0]  mul_b_reg;
    logic         div_start_reg;
    logic [63:0]  div_a_reg;
    logic [63:0]  div_b_reg;
    logic         sqrt_start_reg;
    logic [63:0]  sqrt_a_reg;
    op_req_t      mul_req;
    op_req_t      div_req;
    op_req_t      sqrt_req;

    logic         in_accept;
    logic         out_accept;
    logic         out_load;
    logic         store_busy;
    logic         mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic [31:0]  mem_rd_data;
    logic         mem_wr_en;
    logic [31:0]  mem_wr_data;
    logic         mul_done;
    logic [127:0] mul_prod;
    logic         div_done;
    logic [63:0]  div_quot;
    logic         sqrt_done;
    logic [63:0]  sqrt_root;

    logic [31:0]  inflow;
    logic [32:0]  avail_sum;
    logic [31:0]  avail_now;
    logic [63:0]  e_round;
    logic [63:0]  om_now;
    logic [63:0]  p_now;
    logic [63:0]  p_next_b;
    logic [31:0]  to_chn_now;
    logic [31:0]  keep_now;
    logic [32:0]  store_sum;

    // Unit requests gathered from their start and operand registers.
    assign mul_req  = '{start: mul_start_reg, a: mul_a_reg, b: mul_b_reg};
    assign div_req  = '{start: div_start_reg, a: div_a_reg, b: div_b_reg};
    assign sqrt_req = '{start: sqrt_start_reg, a: sqrt_a_reg, b: 64'd0};

    // Arithmetic units.
    icr_mul u_mul (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (mul_req),
        .done (mul_done),
        .prod (mul_prod)
    );

    icr_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .done (div_done),
        .quot (div_quot)
    );

    icr_sqrt u_sqrt (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (sqrt_req),
        .done (sqrt_done),
        .root (sqrt_root)
    );

    icr_store #(
        .NUM_CELLS(NUM_CELLS)
    ) u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (mem_rd_en),
        .rd_addr(mem_rd_addr),
        .rd_data(mem_rd_data),
        .wr_en  (mem_wr_en),
        .wr_addr(AW'(item_reg.downstream_index)),
        .wr_data(mem_wr_data),
        .busy   (store_busy)
    );

    // Handshakes.
    assign in_stall   = (state_reg != S_IDLE) || store_busy;
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;
    assign out_load   = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;

    // Store reads: the cell's own inflow on accept, the downstream entry later.
    always_comb
    begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = AW'(in_data.cell_index);
        if (in_accept)
        begin
            mem_rd_en = (32'(in_data.cell_index) < 32'(NUM_CELLS));
        end
        else if (state_reg == S_D2W)
        begin
            mem_rd_en   = div_done && dst_ok_reg;
            mem_rd_addr = AW'(item_reg.downstream_index);
        end
    end

    // Saturating add into the downstream store entry.
    always_comb
    begin
        store_sum   = {1'b0, mem_rd_data} + {1'b0, down_reg};
        mem_wr_en   = (state_reg == S_ADD);
        mem_wr_data = store_sum[32] ? '1 : store_sum[31:0];
    end

    // Datapath helpers.
    always_comb
    begin
        inflow     = cell_ok_reg ? mem_rd_data : 32'd0;
        avail_sum  = {1'b0, inflow} + {1'b0, item_reg.vadose_excess};
        avail_now  = avail_sum[32] ? '1 : avail_sum[31:0];
        e_round    = e_reg + 64'h0000_0000_2000_0000;
        om_now     = x_big_reg ? ONE_Q32 : ONE_Q32 - {31'd0, e_round[62:30]};
        to_chn_now = (p_reg < {32'd0, avail_reg}) ? p_reg[31:0] : avail_reg;
        keep_now   = div_quot[31:0];
        p_now      = '0;
        p_next_b   = '0;
        unique case (pstep_reg)
            3'd0:
            begin
                p_now    = mul_shr(mul_prod, 40);
                p_next_b = om_reg;
            end
            3'd1:
            begin
                p_now    = mul_shr(mul_prod, 32);
                p_next_b = {32'd0, item_reg.channel_factor};
            end
            3'd2:
            begin
                p_now    = mul_shr(mul_prod, 28);
                p_next_b = {32'd0, sod_reg};
            end
            3'd3:
            begin
                p_now    = mul_shr(mul_prod, 16);
                p_next_b = {8'd0, lenics_reg};
            end
            default:
            begin
                p_now    = mul_shr(mul_prod, 40);
                p_next_b = '0;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sod_reg <= STEP_OVER_DX_RST;
            ics_reg <= INV_CELL_RST;
            thr_reg <= THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STEP_OVER_DX: sod_reg <= cfg_data;
                CFG_INV_CELL:     ics_reg <= cfg_data;
                CFG_THRESHOLD:    thr_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_accept)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg.out_cell         <= item_reg.cell_index;
            out_reg.remaining_vadose <= keep_reg;
            out_reg.flow_to_channel  <= to_chn_reg;
            out_reg.flow_downstream  <= down_reg;
        end
    end

    // Sequencer state and unit start pulses.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mul_start_reg  <= 1'b0;
            div_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;
        end
        else
        begin
            mul_start_reg  <= 1'b0;
            div_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    if (avail_now > thr_reg)
                    begin
                        mul_start_reg <= 1'b1;
                        state_reg <= (item_reg.channel_length != 24'd0) ? S_KXW : S_SSW;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_KXW:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_EXP;
                    end
                end
                S_EXP:
                begin
                    priority if (x_big_reg || bit_reg == 5'(EXP_BITS))
                    begin
                        mul_start_reg <= 1'b1;
                        state_reg <= S_PW;
                    end
                    else if (x_reg[bit_reg])
                    begin
                        mul_start_reg <= 1'b1;
                        state_reg <= S_EXPW;
                    end
                end
                S_EXPW:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_EXP;
                    end
                end
                S_PW:
                begin
                    if (mul_done)
                    begin
                        if (pstep_reg == 3'd4)
                        begin
                            state_reg <= S_CH;
                        end
                        else
                        begin
                            mul_start_reg <= 1'b1;
                        end
                    end
                end
                S_CH:
                begin
                    mul_start_reg <= 1'b1;
                    state_reg <= S_SSW;
                end
                S_SSW:
                begin
                    if (mul_done)
                    begin
                        sqrt_start_reg <= 1'b1;
                        state_reg <= S_SQW;
                    end
                end
                S_SQW:
                begin
                    if (sqrt_done)
                    begin
                        div_start_reg <= 1'b1;
                        state_reg <= S_D1W;
                    end
                end
                S_D1W:
                begin
                    if (div_done)
                    begin
                        mul_start_reg <= 1'b1;
                        state_reg <= S_ALW;
                    end
                end
                S_ALW:
                begin
                    if (mul_done)
                    begin
                        mul_start_reg <= 1'b1;
                        state_reg <= S_GW;
                    end
                end
                S_GW:
                begin
                    if (mul_done)
                    begin
                        div_start_reg <= 1'b1;
                        state_reg <= S_D2W;
                    end
                end
                S_D2W:
                begin
                    if (div_done)
                    begin
                        state_reg <= dst_ok_reg ? S_ADD : S_OUT;
                    end
                end
                S_ADD:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers and unit operands.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    item_reg    <= in_data;
                    cell_ok_reg <= (32'(in_data.cell_index) < 32'(NUM_CELLS));
                    dst_ok_reg  <= in_data.has_downstream
                                   && (32'(in_data.downstream_index) < 32'(NUM_CELLS));
                end
            end
            S_LOAD:
            begin
                avail_reg  <= avail_now;
                lenics_reg <= {32'd0, item_reg.channel_length} * {24'd0, ics_reg};
                to_chn_reg <= '0;
                keep_reg   <= item_reg.vadose_excess;
                down_reg   <= '0;
                if (item_reg.channel_length != 24'd0)
                begin
                    mul_a_reg <= {32'd0, item_reg.decay_coefficient};
                    mul_b_reg <= {32'd0, avail_now};
                end
                else
                begin
                    mul_a_reg <= {32'd0, item_reg.slope_tangent};
                    mul_b_reg <= {32'd0, item_reg.slope_tangent};
                end
            end
            S_KXW:
            begin
                x_reg     <= mul_prod[52:24];
                x_big_reg <= |mul_prod[63:53];
                e_reg     <= ONE_Q62;
                bit_reg   <= '0;
            end
            S_EXP:
            begin
                priority if (x_big_reg || bit_reg == 5'(EXP_BITS))
                begin
                    om_reg    <= om_now;
                    pstep_reg <= '0;
                    mul_a_reg <= {32'd0, avail_reg};
                    mul_b_reg <= {32'd0, item_reg.conductivity};
                end
                else if (x_reg[bit_reg])
                begin
                    mul_a_reg <= e_reg;
                    mul_b_reg <= EXP_TAB[bit_reg];
                end
                else
                begin
                    bit_reg <= bit_reg + 5'd1;
                end
            end
            S_EXPW:
            begin
                if (mul_done)
                begin
                    e_reg   <= mul_q62(mul_prod);
                    bit_reg <= bit_reg + 5'd1;
                end
            end
            S_PW:
            begin
                if (mul_done)
                begin
                    p_reg     <= p_now;
                    pstep_reg <= pstep_reg + 3'd1;
                    mul_a_reg <= p_now;
                    mul_b_reg <= p_next_b;
                end
            end
            S_CH:
            begin
                to_chn_reg <= to_chn_now;
                avail_reg  <= avail_reg - to_chn_now;
                mul_a_reg  <= {32'd0, item_reg.slope_tangent};
                mul_b_reg  <= {32'd0, item_reg.slope_tangent};
            end
            S_SSW:
            begin
                sqrt_a_reg <= 64'h0040_0000_0000_0000 + {2'd0, mul_prod[63:2]};
            end
            S_SQW:
            begin
                div_a_reg <= {1'b0, item_reg.slope_tangent, 31'd0};
                div_b_reg <= sqrt_root;
            end
            S_D1W:
            begin
                mul_a_reg <= {32'd0, item_reg.conductivity};
                mul_b_reg <= (div_quot > ONE_Q32) ? ONE_Q32 : div_quot;
            end
            S_ALW:
            begin
                mul_a_reg <= {32'd0, mul_prod[63:32]};
                mul_b_reg <= {32'd0, sod_reg};
            end
            S_GW:
            begin
                div_a_reg <= {avail_reg, 32'd0};
                div_b_reg <= ONE_Q32 + {24'd0, mul_prod[63:24]};
            end
            S_D2W:
            begin
                if (div_done)
                begin
                    keep_reg <= keep_now;
                    down_reg <= avail_reg - keep_now;
                end
            end
            S_ADD:
            begin
            end
            S_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

endmodule
